// File: rtl/event_record_timestamp_rewriter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the event record timestamp rewriter
// Shared concurrent assertion wrappers, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef EVENT_RECORD_TIMESTAMP_REWRITER_CORE_MACROS_SVH
`define EVENT_RECORD_TIMESTAMP_REWRITER_CORE_MACROS_SVH

// Check a property outside of reset.
`define ERTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ERTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/erts_pkg.sv
// ----------------------------------------------------------------------------
// erts_pkg
// Types, constants and codes shared by the timestamp rewriter modules.
// ----------------------------------------------------------------------------
package erts_pkg;

  // Record format
  localparam int unsigned HDR_LEN     = 3;
  localparam int unsigned FOOTER_LEN  = 10;
  localparam int unsigned STAMP_BYTES = 4;
  localparam int unsigned BEAT_W      = $clog2(FOOTER_LEN);

  localparam logic [7:0]  TYPE_EVENT  = 8'd4;
  localparam logic [7:0]  TYPE_FOOTER = 8'd7;
  localparam logic [7:0]  TYPE_MAX    = 8'd8;
  localparam logic [7:0]  FV_LATE_STAMP = 8'd70;
  localparam logic [15:0] STAMP_OFS_EARLY = 16'd0;
  localparam logic [15:0] STAMP_OFS_LATE  = 16'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // Time keeping: elapsed ms is held as minutes (mod 64) plus ms in minute
  localparam longint unsigned MS_PER_MIN = 60000;
  localparam longint unsigned MS_PER_SEC = 1000;
  localparam longint unsigned WRAP_SPAN  = 64'd1 << 32;
  localparam longint unsigned WRAP_REM   = WRAP_SPAN % MS_PER_MIN;
  localparam longint unsigned WRAP_QUOT  = WRAP_SPAN / MS_PER_MIN;
  // on a 32-bit wrap, remainder gains (MS_PER_MIN - WRAP_REM), minutes lose
  // WRAP_QUOT + 1
  localparam logic [17:0] WRAP_REM_ADJ = 18'(MS_PER_MIN - WRAP_REM);
  localparam logic [5:0]  WRAP_MIN_ADJ = 6'((WRAP_QUOT + 1) % 64);
  localparam logic [17:0] ONE_MIN  = 18'(MS_PER_MIN);
  localparam logic [17:0] TWO_MIN  = 18'(2 * MS_PER_MIN);
  // seconds = (r * SEC_RECIP) >> SEC_SHIFT, exact for r below one minute
  localparam int unsigned SEC_SHIFT = 26;
  localparam logic [16:0] SEC_RECIP = 17'(((64'd1 << SEC_SHIFT) + MS_PER_SEC - 1) / MS_PER_SEC);
  localparam logic [9:0]  MS_SEC   = 10'(MS_PER_SEC);

  // Command queue depth
  localparam int unsigned CMD_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_BASE_HOUR      = 3'd0,
    CFG_BASE_MINUTE    = 3'd1,
    CFG_BASE_SECOND    = 3'd2,
    CFG_BASE_DAY       = 3'd3,
    CFG_BASE_MONTH     = 3'd4,
    CFG_BASE_YEAR      = 3'd5,
    CFG_STEP_MS        = 3'd6,
    CFG_FORMAT_VERSION = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0]  base_hour;
    logic [5:0]  base_minute;
    logic [5:0]  base_second;
    logic [4:0]  base_day;
    logic [3:0]  base_month;
    logic [15:0] base_year;
    logic [15:0] step_ms;
    logic [7:0]  format_version;
  } cfg_t;

  // Channel payloads
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic [1:0] status;
  } res_t;

  // Header parser phase
  typedef enum logic [3:0] {
    PH_LEN_HI = 4'b0001,
    PH_LEN_LO = 4'b0010,
    PH_TYPE   = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_e;

  // Commands from front to back
  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_ERROR  = 2'd2,
    CMD_FOOTER = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] len;
    logic [7:0]  data;
    logic [1:0]  status;
  } cmd_t;

  // Current elapsed time, split for stamping
  typedef struct packed {
    logic [5:0] minutes;
    logic [5:0] sec;
    logic [9:0] ms;
  } time_t;

endpackage

// File: rtl/event_record_timestamp_rewriter_core.sv
// ----------------------------------------------------------------------------
// event_record_timestamp_rewriter_core
// Record stream filter that passes event records with rewritten timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue write side: a byte beat is taken when push_i is high and
//   full_o is low; end_of_stream marks the end instead of a byte.
//   Results are a queue read side: the oldest result sits on pop_data_o while
//   empty_o is low and leaves when pop_i is high.
//   Configuration writes go through cfg_valid_i/cfg_ready_o (always ready);
//   write them only while the block is idle.
//   Throughput: one input beat per cycle while full_o is low. An event header
//   byte yields three results and the end beat ten (one if it truncates a
//   body); the back end drains one result per cycle and a four-entry command
//   queue absorbs the difference, so full_o rises only when the receiver
//   holds pop_i low or a burst is draining.
//   Reset clears the parser, elapsed time and queues and restores register
//   defaults. When pop_i stays low the output stage holds its result and the
//   command queue fills, then full_o stalls the sender.
// ----------------------------------------------------------------------------
module event_record_timestamp_rewriter_core #(
  parameter int unsigned CmdDepth = erts_pkg::CMD_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  erts_pkg::item_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output erts_pkg::res_t  pop_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i
);
  import erts_pkg::*;

  cfg_t  cfg_q;
  time_t cur_time;
  cmd_t  push_cmd, head_cmd;
  logic  accept, advance, cmd_push, cmd_pop, cmd_valid;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{base_hour: 5'd0, base_minute: 6'd0, base_second: 6'd0,
                 base_day: 5'd1, base_month: 4'd1, base_year: 16'd2000,
                 step_ms: 16'd1, format_version: 8'd0};
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BASE_HOUR:      cfg_q.base_hour      <= cfg_data_i[4:0];
        CFG_BASE_MINUTE:    cfg_q.base_minute    <= cfg_data_i[5:0];
        CFG_BASE_SECOND:    cfg_q.base_second    <= cfg_data_i[5:0];
        CFG_BASE_DAY:       cfg_q.base_day       <= cfg_data_i[4:0];
        CFG_BASE_MONTH:     cfg_q.base_month     <= cfg_data_i[3:0];
        CFG_BASE_YEAR:      cfg_q.base_year      <= cfg_data_i;
        CFG_STEP_MS:        cfg_q.step_ms        <= cfg_data_i;
        CFG_FORMAT_VERSION: cfg_q.format_version <= cfg_data_i[7:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  assign accept = push_i && !full_o;

  erts_time u_time (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .step_i    (cfg_q.step_ms),
    .time_o    (cur_time)
  );

  erts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (push_data_i),
    .cfg_i      (cfg_q),
    .time_i     (cur_time),
    .advance_o  (advance),
    .cmd_push_o (cmd_push),
    .cmd_o      (push_cmd)
  );

  erts_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (push_cmd),
    .full_o     (full_o),
    .pop_i      (cmd_pop),
    .valid_o    (cmd_valid),
    .head_o     (head_cmd)
  );

  erts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .res_o       (pop_data_o)
  );

endmodule

// File: rtl/erts_time.sv
// ----------------------------------------------------------------------------
// erts_time
// Elapsed-time keeper: minutes and ms-in-minute updated per event, with a
// two-stage split of the remainder into seconds and milliseconds.
// ----------------------------------------------------------------------------
module erts_time (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic [15:0]     step_i,
  output erts_pkg::time_t time_o
);
  import erts_pkg::*;

  logic [31:0] elapsed_q, elapsed_d;
  logic [5:0]  min_q, min_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] prod_q;
  logic [15:0] rem_dly_q;
  logic [5:0]  sec_q;
  logic [9:0]  ms_q;

  logic [32:0] sum;
  logic        wrap;
  logic [17:0] rem_sum;
  logic [1:0]  carry_min;
  logic [32:0] prod_full;
  logic [5:0]  sec_next;
  logic [15:0] sec_ms;

  // Add the step, keep minutes and remainder in sync
  always_comb begin
    sum     = {1'b0, elapsed_q} + {17'd0, step_i};
    wrap    = sum[32];
    rem_sum = {2'd0, rem_q} + {2'd0, step_i} + (wrap ? WRAP_REM_ADJ : 18'd0);
    priority if (rem_sum >= TWO_MIN) begin
      carry_min = 2'd2;
    end else if (rem_sum >= ONE_MIN) begin
      carry_min = 2'd1;
    end else begin
      carry_min = 2'd0;
    end
    elapsed_d = elapsed_q;
    min_d     = min_q;
    rem_d     = rem_q;
    if (advance_i) begin
      elapsed_d = sum[31:0];
      rem_d     = 16'(rem_sum - ({16'd0, carry_min} * ONE_MIN));
      min_d     = min_q + {4'd0, carry_min} - (wrap ? WRAP_MIN_ADJ : 6'd0);
    end
  end

  // Split remainder into seconds and ms
  assign prod_full = {1'b0, rem_q} * SEC_RECIP;
  assign sec_next  = prod_q[SEC_SHIFT +: 6];
  assign sec_ms    = 16'({10'd0, sec_next} * {6'd0, MS_SEC});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      min_q     <= '0;
      rem_q     <= '0;
      prod_q    <= '0;
      rem_dly_q <= '0;
      sec_q     <= '0;
      ms_q      <= '0;
    end else begin
      elapsed_q <= elapsed_d;
      min_q     <= min_d;
      rem_q     <= rem_d;
      prod_q    <= prod_full[31:0];
      rem_dly_q <= rem_q;
      sec_q     <= sec_next;
      ms_q      <= 10'(rem_dly_q - sec_ms);
    end
  end

  assign time_o = '{minutes: min_q, sec: sec_q, ms: ms_q};

endmodule

// File: rtl/erts_front.sv
// ----------------------------------------------------------------------------
// erts_front
// Record parser: tracks headers and body position, rewrites stamp bytes and
// queues one command per input byte that yields results.
// ----------------------------------------------------------------------------
module erts_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  erts_pkg::item_t item_i,
  input  erts_pkg::cfg_t  cfg_i,
  input  erts_pkg::time_t time_i,
  output logic            advance_o,
  output logic            cmd_push_o,
  output erts_pkg::cmd_t  cmd_o
);
  import erts_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] rec_len_q, rec_len_d;
  logic [15:0] pos_q, pos_d;
  logic        event_q, event_d;
  logic        halted_q, halted_d;
  logic [27:0] stamp_q, stamp_d;

  logic [5:0]  minute;
  logic [10:0] ms_ext;
  logic [27:0] stamp_new;
  logic [15:0] stamp_start;
  logic [15:0] pos_off;
  logic        in_win;
  logic [7:0]  out_byte;
  logic [15:0] pos_next;

  // Pack the stamp for the current elapsed time
  always_comb begin
    minute    = cfg_i.base_minute + time_i.minutes;
    ms_ext    = {1'b0, time_i.ms};
    stamp_new = {cfg_i.base_hour, minute[5:3],
                 minute[2:0], time_i.sec[5:1],
                 time_i.sec[0], ms_ext[10:4],
                 ms_ext[3:0]};
  end

  // Rewrite a body byte that falls in the stamp window
  always_comb begin
    stamp_start = (cfg_i.format_version >= FV_LATE_STAMP) ? STAMP_OFS_LATE : STAMP_OFS_EARLY;
    pos_off     = pos_q - stamp_start;
    in_win      = (pos_q >= stamp_start) && (pos_q < stamp_start + 16'(STAMP_BYTES));
    out_byte    = item_i.data_byte;
    if (in_win) begin
      unique case (pos_off[1:0])
        2'd0: out_byte = stamp_q[27:20];
        2'd1: out_byte = stamp_q[19:12];
        2'd2: out_byte = stamp_q[11:4];
        2'd3: out_byte = {stamp_q[3:0], item_i.data_byte[3:0]};
        default: out_byte = item_i.data_byte;
      endcase
    end
    pos_next = pos_q + 16'd1;
  end

  // Classify the byte and step the parser
  always_comb begin
    phase_d    = phase_q;
    len_hi_d   = len_hi_q;
    rec_len_d  = rec_len_q;
    pos_d      = pos_q;
    event_d    = event_q;
    halted_d   = halted_q;
    stamp_d    = stamp_q;
    advance_o  = 1'b0;
    cmd_push_o = 1'b0;
    cmd_o      = '{kind: CMD_BYTE, len: rec_len_q, data: out_byte, status: ST_OK};
    if (accept_i && !halted_q) begin
      if (item_i.end_of_stream) begin
        halted_d   = 1'b1;
        cmd_push_o = 1'b1;
        if (phase_q == PH_BODY) begin
          cmd_o.kind   = CMD_ERROR;
          cmd_o.status = ST_TRUNC;
        end else begin
          cmd_o.kind = CMD_FOOTER;
        end
      end else begin
        unique case (phase_q)
          PH_LEN_HI: begin
            len_hi_d = item_i.data_byte;
            phase_d  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            rec_len_d = {len_hi_q, item_i.data_byte};
            phase_d   = PH_TYPE;
          end
          PH_TYPE: begin
            if (item_i.data_byte > TYPE_MAX || rec_len_q < 16'(HDR_LEN)) begin
              halted_d     = 1'b1;
              cmd_push_o   = 1'b1;
              cmd_o.kind   = CMD_ERROR;
              cmd_o.status = ST_BAD;
            end else begin
              event_d = (item_i.data_byte == TYPE_EVENT);
              pos_d   = '0;
              phase_d = (rec_len_q == 16'(HDR_LEN)) ? PH_LEN_HI : PH_BODY;
              if (item_i.data_byte == TYPE_EVENT) begin
                stamp_d    = stamp_new;
                advance_o  = 1'b1;
                cmd_push_o = 1'b1;
                cmd_o.kind = CMD_HEADER;
                cmd_o.data = item_i.data_byte;
              end
            end
          end
          PH_BODY: begin
            pos_d = pos_next;
            if (pos_next >= rec_len_q - 16'(HDR_LEN)) begin
              phase_d = PH_LEN_HI;
            end
            cmd_push_o = event_q;
          end
          default: phase_d = PH_LEN_HI;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEN_HI;
      len_hi_q  <= '0;
      rec_len_q <= '0;
      pos_q     <= '0;
      event_q   <= 1'b0;
      halted_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      len_hi_q  <= len_hi_d;
      rec_len_q <= rec_len_d;
      pos_q     <= pos_d;
      event_q   <= event_d;
      halted_q  <= halted_d;
    end
  end

  // Stamp holds payload only
  always_ff @(posedge clk_i) begin
    stamp_q <= stamp_d;
  end

endmodule

// File: rtl/erts_cmd_fifo.sv
// ----------------------------------------------------------------------------
// erts_cmd_fifo
// Short command queue between parser and output sequencer.
// ----------------------------------------------------------------------------
module erts_cmd_fifo #(
  parameter int unsigned Depth = erts_pkg::CMD_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  erts_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output erts_pkg::cmd_t head_o
);
  import erts_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/erts_back.sv
// ----------------------------------------------------------------------------
// erts_back
// Output sequencer: expands each command into result beats, one per cycle
// while the output stage is free or popped, into a registered output stage.
// ----------------------------------------------------------------------------
module erts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  erts_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  input  erts_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output erts_pkg::res_t res_o
);
  import erts_pkg::*;

  logic [BEAT_W-1:0] beat_q;
  logic              out_valid_q;
  res_t              res_q;

  logic              advance;
  logic [BEAT_W-1:0] last_beat;
  logic              is_last;
  logic [7:0]        beat_byte;
  logic [7:0]        footer_bytes [FOOTER_LEN];
  logic [7:0]        header_bytes [HDR_LEN];

  // Footer record and event header, byte by byte
  always_comb begin
    footer_bytes[0] = 8'(FOOTER_LEN >> 8);
    footer_bytes[1] = 8'(FOOTER_LEN);
    footer_bytes[2] = TYPE_FOOTER;
    footer_bytes[3] = cfg_i.base_year[15:8];
    footer_bytes[4] = cfg_i.base_year[7:0];
    footer_bytes[5] = {4'd0, cfg_i.base_month};
    footer_bytes[6] = {3'd0, cfg_i.base_day};
    footer_bytes[7] = {3'd0, cfg_i.base_hour};
    footer_bytes[8] = {2'd0, cfg_i.base_minute};
    footer_bytes[9] = {2'd0, cfg_i.base_second};
    header_bytes[0] = cmd_i.len[15:8];
    header_bytes[1] = cmd_i.len[7:0];
    header_bytes[2] = cmd_i.data;
  end

  // Pick the beat for the head command
  always_comb begin
    unique case (cmd_i.kind)
      CMD_BYTE: begin
        last_beat = '0;
        beat_byte = cmd_i.data;
      end
      CMD_HEADER: begin
        last_beat = BEAT_W'(HDR_LEN - 1);
        beat_byte = header_bytes[beat_q[1:0]];
      end
      CMD_ERROR: begin
        last_beat = '0;
        beat_byte = 8'd0;
      end
      CMD_FOOTER: begin
        last_beat = BEAT_W'(FOOTER_LEN - 1);
        beat_byte = footer_bytes[beat_q];
      end
      default: begin
        last_beat = '0;
        beat_byte = 8'd0;
      end
    endcase
    is_last   = (beat_q == last_beat);
    advance   = !out_valid_q || pop_i;
    cmd_pop_o = advance && cmd_valid_i && is_last;
  end

  // Load the output stage whenever it frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= '0;
    end else if (advance) begin
      out_valid_q <= cmd_valid_i;
      if (cmd_valid_i) begin
        beat_q <= is_last ? '0 : beat_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && cmd_valid_i) begin
      res_q <= '{out_byte: beat_byte, last_of_run: is_last, status: cmd_i.status};
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/erts_checker.sv
// ----------------------------------------------------------------------------
// erts_checker
// Port-level assertions for the timestamp rewriter, bound to the top level.
// ----------------------------------------------------------------------------
`include "event_record_timestamp_rewriter_core_macros.svh"

module erts_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           full_i,
  input logic           pop_i,
  input logic           empty_i,
  input erts_pkg::res_t pop_data_i
);
  import erts_pkg::*;

  // Reset leaves both queues drained from the next edge on
  `ERTS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (empty_i && !full_i), "queues not idle in reset")

  // Error beats carry a zero byte and close their run
  `ERTS_ASSERT(a_err_beat, clk_i, rst_ni, (!empty_i && pop_data_i.status != ST_OK) |-> (pop_data_i.out_byte == 8'd0 && pop_data_i.last_of_run), "bad error beat")

  // Status stays within the defined codes
  `ERTS_ASSERT(a_status_code, clk_i, rst_ni, !empty_i |-> (pop_data_i.status == ST_OK || pop_data_i.status == ST_BAD || pop_data_i.status == ST_TRUNC), "undefined status")

  // A run continues without a gap once started
  `ERTS_ASSERT(a_run_gapless, clk_i, rst_ni, (!empty_i && pop_i && !pop_data_i.last_of_run) |=> !empty_i, "gap inside a run")

  // A stalled result holds
  `ERTS_ASSERT(a_hold_stall, clk_i, rst_ni, (!empty_i && !pop_i) |=> (!empty_i && $stable(pop_data_i)), "stalled result changed")

endmodule

bind event_record_timestamp_rewriter_core erts_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full_i     (full_o),
  .pop_i      (pop_i),
  .empty_i    (empty_o),
  .pop_data_i (pop_data_o)
);

// File: bench/event_record_timestamp_rewriter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_record_timestamp_rewriter_core_tb
// Streams records through the rewriter, one byte beat at a time, and checks
// every result beat against an in-bench model of the parser, the timestamp
// packer and the footer. Settings change between phases while the block is
// idle. The stream ends in one randomly chosen way: clean end (possibly
// inside a header), truncated body, bad type or short length.
// ----------------------------------------------------------------------------
module event_record_timestamp_rewriter_core_tb;
  import erts_pkg::*;

  localparam int unsigned     CLK_HALF_NS   = 5;
  localparam int unsigned     RESET_CYCLES  = 12;
  localparam int unsigned     RANDOM_BEATS  = 450;
  localparam int unsigned     PHASE_BEATS   = 45;
  localparam int unsigned     IDLE_PCT      = 8;
  localparam int unsigned     QUIET_PHASE   = 3;
  localparam int unsigned     SETTLE_CYCLES = 4;
  localparam int unsigned     TAIL_CYCLES   = 40;
  localparam longint unsigned RUN_LIMIT_NS  = 5_000_000;
  localparam logic [7:0]      TYPE_LOWEST   = 8'd0;

  // Settings profiles for the phases
  localparam int unsigned PROFILE_LOW  = 0;
  localparam int unsigned PROFILE_HIGH = 1;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push_i      = 1'b0;
  item_t       push_data_i = '0;
  logic        full_o;
  logic        pop_i       = 1'b0;
  logic        empty_o;
  res_t        pop_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  item_t       pending_beats[$];
  res_t        awaited_results[$];
  res_t        oldest_result;
  logic        beat_taken   = 1'b0;
  int unsigned idle_pct     = IDLE_PCT;
  int unsigned queued_beats = 0;
  int unsigned mismatches   = 0;

  // Model copy of the settings and parser state
  cfg_t        base_cfg;
  phase_e      parse_phase;
  logic [7:0]  len_high;
  logic [15:0] rec_len;
  logic [15:0] body_count;
  logic        passing_event;
  logic [31:0] ms_elapsed;
  logic [27:0] new_stamp;
  logic        stream_halted;

  event_record_timestamp_rewriter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .push_data_i (push_data_i),
    .full_o      (full_o),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .pop_data_o  (pop_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Advance the model by one accepted beat and queue the bytes it produces
  function automatic void rewrite_beat(item_t beat);
    res_t        run[$];
    logic [7:0]  footer[FOOTER_LEN];
    logic [15:0] stamp_ofs;
    logic [15:0] k;
    logic [7:0]  ob;
    logic [31:0] minutes_total;
    logic [31:0] sec_val;
    logic [31:0] ms_val;
    if (stream_halted) return;
    if (beat.end_of_stream) begin
      stream_halted = 1'b1;
      if (parse_phase == PH_BODY) begin
        run.push_back({8'h00, 1'b0, ST_TRUNC});
      end else begin
        footer = '{8'(FOOTER_LEN >> 8), 8'(FOOTER_LEN), TYPE_FOOTER,
                   base_cfg.base_year[15:8], base_cfg.base_year[7:0],
                   8'(base_cfg.base_month), 8'(base_cfg.base_day),
                   8'(base_cfg.base_hour), 8'(base_cfg.base_minute),
                   8'(base_cfg.base_second)};
        foreach (footer[i]) run.push_back({footer[i], 1'b0, ST_OK});
      end
    end else begin
      case (parse_phase)
        PH_LEN_HI: begin
          len_high    = beat.data_byte;
          parse_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          rec_len     = {len_high, beat.data_byte};
          parse_phase = PH_TYPE;
        end
        PH_TYPE: begin
          if (beat.data_byte > TYPE_MAX || rec_len < 16'(HDR_LEN)) begin
            stream_halted = 1'b1;
            run.push_back({8'h00, 1'b0, ST_BAD});
          end else begin
            passing_event = (beat.data_byte == TYPE_EVENT);
            body_count    = '0;
            parse_phase   = (rec_len == 16'(HDR_LEN)) ? PH_LEN_HI : PH_BODY;
            if (passing_event) begin
              // Pack hour, wrapped minute, second and ms from the elapsed time
              minutes_total = 32'(base_cfg.base_minute) + 32'(ms_elapsed / MS_PER_MIN);
              sec_val       = 32'((ms_elapsed % MS_PER_MIN) / MS_PER_SEC);
              ms_val        = 32'(ms_elapsed % MS_PER_SEC);
              new_stamp     = {base_cfg.base_hour, minutes_total[5:0], sec_val[5:0],
                               ms_val[10:0]};
              ms_elapsed    = ms_elapsed + 32'(base_cfg.step_ms);
              run.push_back({rec_len[15:8], 1'b0, ST_OK});
              run.push_back({rec_len[7:0], 1'b0, ST_OK});
              run.push_back({beat.data_byte, 1'b0, ST_OK});
            end
          end
        end
        default: begin
          stamp_ofs = (base_cfg.format_version >= FV_LATE_STAMP) ? STAMP_OFS_LATE
                                                                 : STAMP_OFS_EARLY;
          ob = beat.data_byte;
          // Replace the bytes inside the stamp window, keep the last low nibble
          if (body_count >= stamp_ofs && body_count < stamp_ofs + 16'(STAMP_BYTES)) begin
            k = body_count - stamp_ofs;
            case (k)
              16'd0:   ob = new_stamp[27:20];
              16'd1:   ob = new_stamp[19:12];
              16'd2:   ob = new_stamp[11:4];
              default: ob = {new_stamp[3:0], beat.data_byte[3:0]};
            endcase
          end
          body_count = body_count + 16'd1;
          if (body_count >= rec_len - 16'(HDR_LEN)) parse_phase = PH_LEN_HI;
          if (passing_event) run.push_back({ob, 1'b0, ST_OK});
        end
      endcase
    end
    if (run.size() != 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) awaited_results.push_back(run[i]);
  endfunction

  function automatic void queue_byte(logic [7:0] value);
    pending_beats.push_back({value, 1'b0});
    queued_beats++;
  endfunction

  function automatic void queue_end();
    pending_beats.push_back({8'($urandom), 1'b1});
    queued_beats++;
  endfunction

  function automatic void queue_header(logic [15:0] len, logic [7:0] kind);
    queue_byte(len[15:8]);
    queue_byte(len[7:0]);
    queue_byte(kind);
  endfunction

  function automatic void queue_record(logic [7:0] kind, int unsigned body_len);
    queue_header(16'(body_len + HDR_LEN), kind);
    repeat (body_len) queue_byte(8'($urandom));
  endfunction

  // Hold until every queued beat is taken and every result has come back
  task automatic wait_idle(int unsigned extra_cycles);
    while (pending_beats.size() != 0 || push_i || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (extra_cycles) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_BASE_HOUR:   base_cfg.base_hour      = value[4:0];
      CFG_BASE_MINUTE: base_cfg.base_minute    = value[5:0];
      CFG_BASE_SECOND: base_cfg.base_second    = value[5:0];
      CFG_BASE_DAY:    base_cfg.base_day       = value[4:0];
      CFG_BASE_MONTH:  base_cfg.base_month     = value[3:0];
      CFG_BASE_YEAR:   base_cfg.base_year      = value;
      CFG_STEP_MS:     base_cfg.step_ms        = value;
      default:         base_cfg.format_version = value[7:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Write all registers: lowest values, highest values, or random ones
  task automatic write_settings(int unsigned profile);
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [15:0] step;
    logic [7:0]  version;
    case (profile)
      PROFILE_LOW: begin
        hour = '0; minute = '0; second = '0; day = 5'd1; month = 4'd1;
        year = '0; step = '0; version = '0;
      end
      PROFILE_HIGH: begin
        hour = 5'd23; minute = 6'd59; second = 6'd59; day = 5'd31; month = 4'd12;
        year = 16'hFFFF; step = 16'hFFFF; version = 8'hFF;
      end
      default: begin
        hour   = 5'($urandom_range(23));
        minute = 6'($urandom_range(59));
        second = 6'($urandom_range(59));
        day    = 5'($urandom_range(31, 1));
        month  = 4'($urandom_range(12, 1));
        year   = 16'($urandom_range(65535));
        step   = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(1500));
        // Favor the versions on either side of the stamp offset switch
        case ($urandom_range(3))
          0:       version = FV_LATE_STAMP - 8'd1;
          1:       version = FV_LATE_STAMP;
          2:       version = 8'($urandom_range(FV_LATE_STAMP - 1));
          default: version = 8'($urandom_range(255, FV_LATE_STAMP));
        endcase
      end
    endcase
    write_register(CFG_BASE_HOUR, 16'(hour));
    write_register(CFG_BASE_MINUTE, 16'(minute));
    write_register(CFG_BASE_SECOND, 16'(second));
    write_register(CFG_BASE_DAY, 16'(day));
    write_register(CFG_BASE_MONTH, 16'(month));
    write_register(CFG_BASE_YEAR, year);
    write_register(CFG_STEP_MS, step);
    write_register(CFG_FORMAT_VERSION, 16'(version));
  endtask

  // Drive the next byte beat once the previous one is taken; randomly drop pop
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push_i <= 1'b0;
      pop_i  <= 1'b0;
    end else begin
      if (!push_i || beat_taken) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
          push_i      <= 1'b1;
          push_data_i <= pending_beats.pop_front();
        end else begin
          push_i <= 1'b0;
        end
      end
      pop_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Predict on every accepted input beat, check every popped result beat
  always @(posedge clk_i) begin
    beat_taken = push_i && !full_o;
    if (rst_ni) begin
      if (beat_taken) rewrite_beat(push_data_i);
      if (pop_i && !empty_o) begin
        if (awaited_results.size() == 0) begin
          $error("result beat 0x%02h arrived with none expected", pop_data_o.out_byte);
          mismatches++;
        end else begin
          oldest_result = awaited_results.pop_front();
          if (pop_data_o.out_byte !== oldest_result.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h",
                   oldest_result.out_byte, pop_data_o.out_byte);
            mismatches++;
          end
          if (pop_data_o.last_of_run !== oldest_result.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d",
                   oldest_result.last_of_run, pop_data_o.last_of_run);
            mismatches++;
          end
          if (pop_data_o.status !== oldest_result.status) begin
            $error("status: expected %0d, got %0d",
                   oldest_result.status, pop_data_o.status);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned phase_start;
    int unsigned random_start;
    int unsigned body_len;
    int unsigned pick;
    logic [7:0]  kind;

    base_cfg.base_hour      = '0;
    base_cfg.base_minute    = '0;
    base_cfg.base_second    = '0;
    base_cfg.base_day       = 5'd1;
    base_cfg.base_month     = 4'd1;
    base_cfg.base_year      = 16'd2000;
    base_cfg.step_ms        = 16'd1;
    base_cfg.format_version = '0;
    parse_phase   = PH_LEN_HI;
    len_high      = '0;
    rec_len       = '0;
    body_count    = '0;
    passing_event = 1'b0;
    ms_elapsed    = '0;
    new_stamp     = '0;
    stream_halted = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full stamp window; the low nibble of the fourth stamp byte survives
    queue_header(16'd7, TYPE_EVENT);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h0F);
    // Highest valid type with an empty body, dropped
    queue_header(16'(HDR_LEN), TYPE_MAX);
    // Event whose body ends inside the stamp window
    queue_header(16'd5, TYPE_EVENT);
    queue_byte(8'hAA);
    queue_byte(8'h55);
    // Event without a body
    queue_header(16'(HDR_LEN), TYPE_EVENT);
    // Lowest type with a body, dropped
    queue_header(16'd4, TYPE_LOWEST);
    queue_byte(8'h81);
    wait_idle(SETTLE_CYCLES);

    // Phases of random records, each under new settings, block idle in between
    random_start = queued_beats;
    phase_no = 0;
    while (queued_beats - random_start < RANDOM_BEATS) begin
      write_settings(phase_no);
      idle_pct = (phase_no == QUIET_PHASE) ? 0 : IDLE_PCT;
      phase_start = queued_beats;
      while (queued_beats - phase_start < PHASE_BEATS) begin
        kind = ($urandom_range(99) < 60) ? TYPE_EVENT : 8'($urandom_range(TYPE_MAX));
        body_len = ($urandom_range(99) < 90) ? $urandom_range(10) : $urandom_range(40, 11);
        queue_record(kind, body_len);
      end
      wait_idle(SETTLE_CYCLES);
      phase_no++;
    end
    idle_pct = IDLE_PCT;

    // Close the stream in one of the terminal ways
    pick = $urandom_range(99);
    if (pick < 45) begin
      queue_end();
    end else if (pick < 65) begin
      // clean end inside a header
      queue_byte(8'($urandom));
      if (pick >= 55) queue_byte(8'($urandom));
      queue_end();
    end else if (pick < 80) begin
      // end inside a body
      body_len = $urandom_range(12, 1);
      kind = $urandom_range(1) ? TYPE_EVENT : 8'($urandom_range(TYPE_MAX));
      queue_header(16'(body_len + HDR_LEN), kind);
      repeat ($urandom_range(body_len - 1)) queue_byte(8'($urandom));
      queue_end();
    end else if (pick < 90) begin
      // type above the highest valid one
      queue_header(16'($urandom_range(40, HDR_LEN)), 8'($urandom_range(255, TYPE_MAX + 1)));
    end else begin
      // length shorter than the header
      queue_header(16'($urandom_range(HDR_LEN - 1)), 8'($urandom_range(TYPE_MAX)));
    end

    // Beats after the halt must produce nothing
    repeat (3) queue_byte(8'($urandom));
    queue_end();

    wait_idle(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/erts_pkg.sv
rtl/erts_time.sv
rtl/erts_front.sv
rtl/erts_cmd_fifo.sv
rtl/erts_back.sv
rtl/event_record_timestamp_rewriter_core.sv
rtl/erts_checker.sv
bench/event_record_timestamp_rewriter_core_tb.sv
